// ----- rtl/shuffled_card_queue_unit_assert.svh -----
// Assertion macros for the checker file of the card queue.
`ifndef SHUFFLED_CARD_QUEUE_UNIT_ASSERT_SVH
`define SHUFFLED_CARD_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SCQ_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("card queue check failed");

// Next-cycle implication, disabled during reset.
`define SCQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("card queue check failed");

`endif

// ----- rtl/scq_pkg.sv -----
package scq_pkg;

   localparam int SCQ_STORE_DEPTH    = 64;
   localparam int SCQ_RANKS_PER_SUIT = 13;
   localparam int SUIT_COUNT         = 4;
   localparam int SUIT_STRIDE        = 16;

   localparam int ACTION_W    = 2;
   localparam int CARD_W      = 6;
   localparam int POS_W       = 6;
   localparam int RAND_W      = 16;
   localparam int COUNT_OUT_W = 7;
   localparam int STATUS_W    = 2;
   localparam int DIVISOR_W   = POS_W + 1;

   localparam logic [ACTION_W-1:0] ACT_DRAW    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_ADD     = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_SHUFFLE = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_QUERY   = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DRAW_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ADD_FULL   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_POS_RANGE  = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic                load_req;
      logic                set_status;
      logic [STATUS_W-1:0] status_code;
      logic                rd_head;
      logic                draw_commit;
      logic                add_commit;
      logic                rd_a;
      logic                rd_b;
      logic                wr_a;
      logic                wr_b;
      logic                load_rsp;
   } scq_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic                is_empty;
      logic                is_full;
      logic                pos_bad;
      logic                partner_same;
      logic                rsp_stall;
   } scq_flags_type;

   // Card held at storage entry k straight after reset: suits in order, ranks from one.
   function automatic logic [CARD_W-1:0] deck_card(input int unsigned k,
                                                   input int unsigned ranks);
      logic [CARD_W-1:0] card;
      card = '0;
      for (int s = SUIT_COUNT - 1; s >= 0; s--) begin
         if (k < (s + 1) * ranks && k >= s * ranks) begin
            card = CARD_W'(s * SUIT_STRIDE + (k - s * ranks) + 1);
         end
      end
      return card;
   endfunction

endpackage

// ----- rtl/scq_if.sv -----
interface scq_req_if
   import scq_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [CARD_W-1:0]   card_in;
   logic [POS_W-1:0]    position;
   logic [RAND_W-1:0]   random_value;

   modport source (output valid, action, card_in, position, random_value, input ready);
   modport sink   (input valid, action, card_in, position, random_value, output ready);
endinterface

interface scq_rsp_if
   import scq_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [CARD_W-1:0]      card_out;
   logic [COUNT_OUT_W-1:0] card_count;
   logic                   is_empty;
   logic [STATUS_W-1:0]    status;

   modport source (output valid, card_out, card_count, is_empty, status, input ready);
   modport sink   (input valid, card_out, card_count, is_empty, status, output ready);
endinterface

// ----- rtl/scq_divider.sv -----
module scq_divider
   import scq_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [RAND_W-1:0]    dividend,
   input  logic [DIVISOR_W-1:0] divisor,
   output logic                 done,
   output logic [DIVISOR_W-1:0] remainder
);
   localparam int STEP_BITS = 2;
   localparam int STEPS     = RAND_W / STEP_BITS;
   localparam int SW        = $clog2(STEPS);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [SW-1:0]        step_ff, step_in;
   logic [RAND_W-1:0]    quo_ff, quo_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] div_ff, div_in;
   logic [DIVISOR_W-1:0] rem_step;
   logic [RAND_W-1:0]    quo_step;

   // two restoring steps per cycle; remainder stays below the divisor
   always_comb begin
      rem_step = rem_ff;
      quo_step = quo_ff;
      for (int k = 0; k < STEP_BITS; k++) begin
         rem_step = {rem_step[DIVISOR_W-2:0], quo_step[RAND_W-1]};
         quo_step = {quo_step[RAND_W-2:0], 1'b0};
         if (rem_step >= div_ff) begin
            rem_step = rem_step - div_ff;
         end
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         step_in = '0;
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         quo_in  = quo_step;
         rem_in  = rem_step;
         step_in = step_ff + 1'b1;
         if (step_ff == SW'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;
endmodule

// ----- rtl/scq_ctrl.sv -----
module scq_ctrl
   import scq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  scq_flags_type flags,
   input  logic          div_done,
   output logic          div_start,
   output scq_cmd_type   cmd
);
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECODE = 4'd1;
   localparam logic [3:0] S_DRAW   = 4'd2;
   localparam logic [3:0] S_DIV    = 4'd3;
   localparam logic [3:0] S_RDA    = 4'd4;
   localparam logic [3:0] S_RDB    = 4'd5;
   localparam logic [3:0] S_WRA    = 4'd6;
   localparam logic [3:0] S_WRB    = 4'd7;
   localparam logic [3:0] S_DONE   = 4'd8;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      div_start = 1'b0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_DONE;
            case (flags.action)
               ACT_DRAW: begin
                  if (flags.is_empty) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = STATUS_DRAW_EMPTY;
                  end else begin
                     cmd.rd_head = 1'b1;
                     state_in    = S_DRAW;
                  end
               end
               ACT_ADD: begin
                  if (flags.is_full) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = STATUS_ADD_FULL;
                  end else begin
                     cmd.add_commit = 1'b1;
                  end
               end
               ACT_SHUFFLE: begin
                  if (flags.pos_bad) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = STATUS_POS_RANGE;
                  end else begin
                     div_start = 1'b1;
                     state_in  = S_DIV;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_DRAW: begin
            cmd.draw_commit = 1'b1;
            state_in        = S_DONE;
         end
         S_DIV: begin
            if (div_done) begin
               state_in = flags.partner_same ? S_DONE : S_RDA;
            end
         end
         S_RDA: begin
            cmd.rd_a = 1'b1;
            state_in = S_RDB;
         end
         S_RDB: begin
            cmd.rd_b = 1'b1;
            state_in = S_WRA;
         end
         S_WRA: begin
            cmd.wr_a = 1'b1;
            state_in = S_WRB;
         end
         S_WRB: begin
            cmd.wr_b = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!flags.rsp_stall) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// ----- rtl/scq_datapath.sv -----
module scq_datapath
   import scq_pkg::*;
#(
   parameter int STORE_DEPTH    = SCQ_STORE_DEPTH,
   parameter int RANKS_PER_SUIT = SCQ_RANKS_PER_SUIT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  scq_cmd_type            cmd,
   output scq_flags_type          flags,
   input  logic [ACTION_W-1:0]    req_action,
   input  logic [CARD_W-1:0]      req_card_in,
   input  logic [POS_W-1:0]       req_position,
   input  logic [RAND_W-1:0]      req_random_value,
   output logic [RAND_W-1:0]      div_dividend,
   output logic [DIVISOR_W-1:0]   div_divisor,
   input  logic [DIVISOR_W-1:0]   div_remainder,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [CARD_W-1:0]      rsp_card_out,
   output logic [COUNT_OUT_W-1:0] rsp_card_count,
   output logic                   rsp_is_empty,
   output logic [STATUS_W-1:0]    rsp_status
);
   localparam int IW          = $clog2(STORE_DEPTH);
   localparam int CW          = $clog2(STORE_DEPTH + 1);
   localparam int DECK_CARDS  = SUIT_COUNT * RANKS_PER_SUIT;
   localparam int RESET_COUNT = (DECK_CARDS < STORE_DEPTH) ? DECK_CARDS : STORE_DEPTH;

   logic [CARD_W-1:0] mem [STORE_DEPTH];
   logic [STORE_DEPTH-1:0] written_ff;

   logic [IW-1:0]       head_ff, head_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [ACTION_W-1:0] action_ff;
   logic [CARD_W-1:0]   card_in_ff;
   logic [POS_W-1:0]    pos_ff;
   logic [RAND_W-1:0]   rnd_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [CARD_W-1:0]   card_out_ff;
   logic [CARD_W-1:0]   tmp_ff;

   logic [CARD_W-1:0] rd_data_ff;
   logic              rd_written_ff;
   logic [IW-1:0]     rd_addr_ff;
   logic [CARD_W-1:0] rd_value;

   logic              rd_en;
   logic [IW-1:0]     rd_addr;
   logic              wr_en;
   logic [IW-1:0]     wr_addr;
   logic [CARD_W-1:0] wr_data;
   logic [IW-1:0]     slot_a;
   logic [IW-1:0]     slot_b;
   logic [IW-1:0]     slot_tail;

   logic                   rsp_valid_ff;
   logic [CARD_W-1:0]      rsp_card_ff;
   logic [COUNT_OUT_W-1:0] rsp_count_ff;
   logic                   rsp_empty_ff;
   logic [STATUS_W-1:0]    rsp_status_ff;
   logic [CW+COUNT_OUT_W-1:0] count_ext;

   // storage index of queue position p; head plus p stays below twice the depth
   function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] head,
                                             input logic [CW-1:0] p);
      logic [IW:0] sum;
      sum = {1'b0, head} + (IW+1)'(p);
      if (sum >= (IW+1)'(STORE_DEPTH)) begin
         sum = sum - (IW+1)'(STORE_DEPTH);
      end
      return sum[IW-1:0];
   endfunction

   assign slot_a    = slot_of(head_ff, CW'(pos_ff));
   assign slot_b    = slot_of(head_ff, CW'(div_remainder));
   assign slot_tail = slot_of(head_ff, count_ff);

   // an entry never written still holds its reset card
   assign rd_value = rd_written_ff ? rd_data_ff
                                   : deck_card(int'(rd_addr_ff), RANKS_PER_SUIT);

   always_comb begin
      rd_en   = cmd.rd_head | cmd.rd_a | cmd.rd_b;
      rd_addr = cmd.rd_head ? head_ff : (cmd.rd_a ? slot_a : slot_b);
      wr_en   = cmd.add_commit | cmd.wr_a | cmd.wr_b;
      wr_addr = slot_b;
      wr_data = tmp_ff;
      if (cmd.add_commit) begin
         wr_addr = slot_tail;
         wr_data = card_in_ff;
      end else if (cmd.wr_a) begin
         wr_addr = slot_a;
         wr_data = rd_value;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff    <= mem[rd_addr];
         rd_written_ff <= written_ff[rd_addr];
         rd_addr_ff    <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (wr_en) begin
         written_ff[wr_addr] <= 1'b1;
      end
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (cmd.draw_commit) begin
         head_in  = (head_ff == IW'(STORE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end else if (cmd.add_commit) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= CW'(RESET_COUNT);
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         action_ff   <= req_action;
         card_in_ff  <= req_card_in;
         pos_ff      <= req_position;
         rnd_ff      <= req_random_value;
         status_ff   <= STATUS_OK;
         card_out_ff <= '0;
      end else begin
         if (cmd.set_status) begin
            status_ff <= cmd.status_code;
         end
         if (cmd.draw_commit) begin
            card_out_ff <= rd_value;
         end
      end
      if (cmd.rd_b) begin
         tmp_ff <= rd_value;
      end
   end

   assign div_dividend = rnd_ff;
   assign div_divisor  = DIVISOR_W'(pos_ff) + 1'b1;

   always_comb begin
      flags.action       = action_ff;
      flags.is_empty     = (count_ff == '0);
      flags.is_full      = (count_ff == CW'(STORE_DEPTH));
      flags.pos_bad      = ((CW+POS_W)'(pos_ff) >= (CW+POS_W)'(count_ff));
      flags.partner_same = (div_remainder == DIVISOR_W'(pos_ff));
      flags.rsp_stall    = rsp_valid_ff & ~rsp_ready;
   end

   assign count_ext = {{COUNT_OUT_W{1'b0}}, count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_card_ff   <= card_out_ff;
         rsp_count_ff  <= count_ext[COUNT_OUT_W-1:0];
         rsp_empty_ff  <= (count_ff == '0);
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_card_out   = rsp_card_ff;
   assign rsp_card_count = rsp_count_ff;
   assign rsp_is_empty   = rsp_empty_ff;
   assign rsp_status     = rsp_status_ff;
endmodule

// ----- rtl/shuffled_card_queue_unit.sv -----
// Card queue: a ring of card codes (suit*16+rank) that starts out as an ordered deck.
// req_chan carries one action per word: draw front, add bottom, shuffle swap step, query.
// rsp_chan returns exactly one word per request: drawn card, count, empty flag, status.
// Steps from request accept to response valid, with the response side free:
//   query, add or any refused action: decode, respond; draw: decode, read, respond;
//   shuffle step: decode, divide, then, when the two positions differ, swap the cards.
// One request is in flight at a time; the next is taken once the response is
// registered. A shuffle step waits on the remainder unit (two bits a cycle for the
// 16-bit random word) and on the card store, with one read port and one write port,
// which needs two reads and two writes for a swap.
// Reset (synchronous, active high) restores the ordered deck at once: head to zero,
// count to four suits of ranks, and per-entry written flags cleared so that unwritten
// entries read back as their deck card. No clearing pass is needed.
// When the receiver stalls, the response word holds in its output register and
// the next request is accepted but waits in the final state until the word is taken.
module shuffled_card_queue_unit
   import scq_pkg::*;
#(
   parameter int STORE_DEPTH    = SCQ_STORE_DEPTH,
   parameter int RANKS_PER_SUIT = SCQ_RANKS_PER_SUIT
) (
   input logic      clock,
   input logic      reset,
   scq_req_if.sink  req_chan,
   scq_rsp_if.source rsp_chan
);
   scq_cmd_type          cmd;
   scq_flags_type        flags;
   logic                 div_start;
   logic                 div_done;
   logic [RAND_W-1:0]    div_dividend;
   logic [DIVISOR_W-1:0] div_divisor;
   logic [DIVISOR_W-1:0] div_remainder;

   // sequence each action: decode, divide, read and write the store, respond
   scq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .flags     (flags),
      .div_done  (div_done),
      .div_start (div_start),
      .cmd       (cmd)
   );

   // hold the store, head, count and the response register
   scq_datapath #(
      .STORE_DEPTH    (STORE_DEPTH),
      .RANKS_PER_SUIT (RANKS_PER_SUIT)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .flags            (flags),
      .req_action       (req_chan.action),
      .req_card_in      (req_chan.card_in),
      .req_position     (req_chan.position),
      .req_random_value (req_chan.random_value),
      .div_dividend     (div_dividend),
      .div_divisor      (div_divisor),
      .div_remainder    (div_remainder),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_card_out     (rsp_chan.card_out),
      .rsp_card_count   (rsp_chan.card_count),
      .rsp_is_empty     (rsp_chan.is_empty),
      .rsp_status       (rsp_chan.status)
   );

   // partner position: random word modulo position plus one
   scq_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .remainder (div_remainder)
   );
endmodule

// ----- rtl/scq_checker.sv -----
`include "shuffled_card_queue_unit_assert.svh"

module scq_checker
   import scq_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [CARD_W-1:0]      card_out,
   input logic [COUNT_OUT_W-1:0] card_count,
   input logic                   is_empty,
   input logic [STATUS_W-1:0]    status
);
   // a stalled response word holds
   `SCQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(card_out) && $stable(card_count) && $stable(is_empty) && $stable(status))

   // a drawn card only comes with a good status
   `SCQ_ASSERT_IMPLIES(a_card_ok, clock, reset, rsp_valid && card_out != '0, status == STATUS_OK)

   // a refused draw reports an empty queue and no card
   `SCQ_ASSERT_IMPLIES(a_draw_empty, clock, reset, rsp_valid && status == STATUS_DRAW_EMPTY, is_empty && card_count == '0 && card_out == '0)

   // one request at a time: ready drops after an accept
   `SCQ_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && req_ready, !req_ready)
endmodule

bind shuffled_card_queue_unit scq_checker u_scq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .card_out   (rsp_chan.card_out),
   .card_count (rsp_chan.card_count),
   .is_empty   (rsp_chan.is_empty),
   .status     (rsp_chan.status)
);

// ----- bench/shuffled_card_queue_unit_tb.sv -----
`timescale 1ns / 1ps

module shuffled_card_queue_unit_tb;
   import scq_pkg::*;

   localparam int DECK_DEPTH   = SCQ_STORE_DEPTH;
   localparam int DECK_RANKS   = SCQ_RANKS_PER_SUIT;
   // Cycles with no word moving on either channel before the run is called hung.
   // The slowest correct gap is a swap plus a sender gap and a receiver stall, or the
   // long hold-off below.
   localparam int QUIET_LIMIT  = 4000;
   localparam int HOLD_CYCLES  = 300;
   // Longest response latency is a swap; the tail at the end covers more than that.
   localparam int TAIL_CYCLES  = 32;
   // Room for expected words; at most two are ever outstanding.
   localparam int EXPECT_SLOTS = 16;

   // One expected response word.
   typedef struct {
      logic [CARD_W-1:0]      card_out;
      logic [COUNT_OUT_W-1:0] card_count;
      logic                   is_empty;
      logic [STATUS_W-1:0]    status;
   } card_result_type;

   logic clock = 1'b0;
   logic reset;

   scq_req_if req_if ();
   scq_rsp_if rsp_if ();

   shuffled_card_queue_unit u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always #2 clock = ~clock;

   // Shadow of the queue: card per storage entry, front entry and number held.
   logic [CARD_W-1:0] shadow_deck [DECK_DEPTH];
   int unsigned       shadow_head;
   int unsigned       shadow_count;

   // Expected words in order of acceptance, kept in a small ring.
   card_result_type   expect_store [EXPECT_SLOTS];
   int unsigned       expect_wr;
   int unsigned       expect_rd;
   card_result_type   oldest_result;

   int                mismatch_count;
   int                actions_sent;
   int                status_seen [4];

   // Idling controls for the sender and the receiver, and the watchdog count.
   bit                send_gaps_on;
   bit                sink_stalls_on;
   int                hold_request;
   int                hold_left;
   int                stall_left;
   int                quiet_cycles;

   // Rebuild the ordered deck: suit by suit, ranks from one, suit 0 at the front.
   task automatic load_ordered_deck();
      int unsigned n;
      n = 0;
      for (int k = 0; k < DECK_DEPTH; k++) begin
         shadow_deck[k] = '0;
      end
      for (int s = 0; s < SUIT_COUNT; s++) begin
         for (int r = 1; r <= DECK_RANKS; r++) begin
            if (n < DECK_DEPTH) begin
               shadow_deck[n] = CARD_W'(s * SUIT_STRIDE + r);
               n++;
            end
         end
      end
      shadow_head  = 0;
      shadow_count = n;
   endtask

   // Apply one accepted action to the shadow queue and queue up its response word.
   task automatic apply_card_action(input logic [ACTION_W-1:0] act,
                                    input logic [CARD_W-1:0]   card,
                                    input logic [POS_W-1:0]    pos,
                                    input logic [RAND_W-1:0]   rnd);
      card_result_type   want;
      int unsigned       partner;
      int unsigned       slot_a;
      int unsigned       slot_b;
      logic [CARD_W-1:0] swap_tmp;
      want.card_out = '0;
      want.status   = STATUS_OK;
      case (act)
         ACT_DRAW: begin
            if (shadow_count == 0) begin
               want.status = STATUS_DRAW_EMPTY;
            end else begin
               want.card_out = shadow_deck[shadow_head];
               shadow_head   = (shadow_head + 1) % DECK_DEPTH;
               shadow_count--;
            end
         end
         ACT_ADD: begin
            if (shadow_count >= DECK_DEPTH) begin
               want.status = STATUS_ADD_FULL;
            end else begin
               shadow_deck[(shadow_head + shadow_count) % DECK_DEPTH] = card;
               shadow_count++;
            end
         end
         ACT_SHUFFLE: begin
            if (int'(pos) >= shadow_count) begin
               want.status = STATUS_POS_RANGE;
            end else begin
               partner = int'(rnd) % (int'(pos) + 1);
               if (partner != int'(pos)) begin
                  slot_a              = (shadow_head + int'(pos)) % DECK_DEPTH;
                  slot_b              = (shadow_head + partner) % DECK_DEPTH;
                  swap_tmp            = shadow_deck[slot_a];
                  shadow_deck[slot_a] = shadow_deck[slot_b];
                  shadow_deck[slot_b] = swap_tmp;
               end
            end
         end
         default: begin
         end
      endcase
      want.card_count = COUNT_OUT_W'(shadow_count);
      want.is_empty   = (shadow_count == 0);
      expect_store[expect_wr % EXPECT_SLOTS] = want;
      expect_wr++;
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Offer one request word, hold it until taken, then predict its response.
   // Valid is left high on return so that a following word goes out back to back.
   task automatic send_action(input logic [ACTION_W-1:0] act,
                              input logic [CARD_W-1:0]   card,
                              input logic [POS_W-1:0]    pos,
                              input logic [RAND_W-1:0]   rnd);
      int gap;
      if (send_gaps_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 13);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.action       <= act;
      req_if.card_in      <= card;
      req_if.position     <= pos;
      req_if.random_value <= rnd;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      apply_card_action(act, card, pos, rnd);
      actions_sent++;
   endtask

   // Fill the unused fields with random noise so their bits toggle across actions.
   task automatic send_draw();
      send_action(ACT_DRAW, CARD_W'($urandom_range(0, 63)), POS_W'($urandom_range(0, 63)),
                  RAND_W'($urandom_range(0, 65535)));
   endtask

   task automatic send_add(input logic [CARD_W-1:0] card);
      send_action(ACT_ADD, card, POS_W'($urandom_range(0, 63)),
                  RAND_W'($urandom_range(0, 65535)));
   endtask

   task automatic send_swap(input logic [POS_W-1:0] pos, input logic [RAND_W-1:0] rnd);
      send_action(ACT_SHUFFLE, CARD_W'($urandom_range(0, 63)), pos, rnd);
   endtask

   task automatic send_query();
      send_action(ACT_QUERY, CARD_W'($urandom_range(0, 63)), POS_W'($urandom_range(0, 63)),
                  RAND_W'($urandom_range(0, 65535)));
   endtask

   // Hand-picked words from the reset deck: swap edges, partner equal to position,
   // out-of-range positions and the extreme card codes.
   task automatic test_directed_cases();
      send_query();
      send_swap(6'd0, 16'hFFFF);              // position 0 always pairs with itself
      send_swap(6'd51, 16'h0000);             // swap front and back
      send_swap(6'd51, 16'd51);               // partner lands on the position itself
      send_swap(6'd52, 16'h1234);             // first position past the count
      send_swap(6'd63, 16'hFFFF);             // top position, out of range
      send_draw();
      send_add(6'h3F);
      send_add(6'h00);
      send_swap(6'd51, 16'h8000);             // now the next-to-last card
      send_add(6'h2A);
      send_add(6'h15);
      send_draw();
      send_action(ACT_QUERY, 6'h3F, 6'h3F, 16'hFFFF);
   endtask

   // Walk position from the back down to the front, as a caller shuffling the deck would.
   task automatic test_fisher_yates_pass();
      int top_pos;
      top_pos = int'(shadow_count) - 1;
      for (int i = top_pos; i >= 0; i--) begin
         send_swap(POS_W'(i), RAND_W'($urandom_range(0, 65535)));
      end
   endtask

   // Draw everything, then push past empty: draws and a swap on an empty queue are refused.
   task automatic test_drain_past_empty();
      while (shadow_count != 0) begin
         send_draw();
      end
      send_draw();
      send_draw();
      send_swap(6'd0, RAND_W'($urandom_range(0, 65535)));
      send_query();
   endtask

   // Add until full, then push past full; the head has moved, so the ring wraps here.
   task automatic test_fill_past_full();
      while (shadow_count < DECK_DEPTH) begin
         send_add(CARD_W'($urandom_range(0, 63)));
      end
      send_add(CARD_W'($urandom_range(0, 63)));
      send_add(CARD_W'($urandom_range(0, 63)));
      send_swap(6'd63, 16'd63);
      send_swap(6'd63, RAND_W'($urandom_range(0, 65535)));
      send_query();
   endtask

   // Stall the receiver for a long stretch while requests keep coming, so the block
   // fills and stops taking words.
   task automatic test_response_backpressure();
      bit saved_gaps;
      saved_gaps   = send_gaps_on;
      send_gaps_on = 1'b0;
      hold_request = HOLD_CYCLES;
      for (int i = 0; i < 12; i++) begin
         case ($urandom_range(0, 3))
            0: send_draw();
            1: send_add(CARD_W'($urandom_range(0, 63)));
            2: send_swap(POS_W'($urandom_range(0, 63)), RAND_W'($urandom_range(0, 65535)));
            default: send_query();
         endcase
      end
      send_gaps_on = saved_gaps;
   endtask

   // Mostly in-range swaps and balanced draws and adds, with some noise positions.
   task automatic test_random_mix(input int n_actions);
      int pick;
      for (int i = 0; i < n_actions; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 22) begin
            send_draw();
         end else if (pick < 44) begin
            send_add(CARD_W'($urandom_range(0, 63)));
         end else if (pick < 90) begin
            if (shadow_count != 0 && $urandom_range(0, 6) != 0) begin
               send_swap(POS_W'($urandom_range(0, shadow_count - 1)),
                         RAND_W'($urandom_range(0, 65535)));
            end else begin
               send_swap(POS_W'($urandom_range(0, 63)), RAND_W'($urandom_range(0, 65535)));
            end
         end else begin
            send_query();
         end
      end
   endtask

   // Receiver: random stall bursts, plus the long hold-off counted out here.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
         rsp_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else if (sink_stalls_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 13) - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // Check each response word against the oldest expectation, field by field.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         status_seen[rsp_if.status]++;
         if (expect_wr == expect_rd) begin
            report_mismatch("response word with nothing expected, count", rsp_if.card_count, -1);
         end else begin
            oldest_result = expect_store[expect_rd % EXPECT_SLOTS];
            expect_rd++;
            if (rsp_if.card_out !== oldest_result.card_out)
               report_mismatch("card_out", rsp_if.card_out, oldest_result.card_out);
            if (rsp_if.card_count !== oldest_result.card_count)
               report_mismatch("card_count", rsp_if.card_count, oldest_result.card_count);
            if (rsp_if.is_empty !== oldest_result.is_empty)
               report_mismatch("is_empty", rsp_if.is_empty, oldest_result.is_empty);
            if (rsp_if.status !== oldest_result.status)
               report_mismatch("status", rsp_if.status, oldest_result.status);
         end
      end
   end

   // Watchdog: reset the quiet count whenever a word moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles, %0d responses outstanding",
                     QUIET_LIMIT, expect_wr - expect_rd);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      mismatch_count = 0;
      actions_sent   = 0;
      expect_wr      = 0;
      expect_rd      = 0;
      hold_request   = 0;
      hold_left      = 0;
      stall_left     = 0;
      quiet_cycles   = 0;
      send_gaps_on   = 1'b1;
      sink_stalls_on = 1'b1;
      for (int k = 0; k < 4; k++) status_seen[k] = 0;
      load_ordered_deck();

      // Hold reset and every request input at a known value from time zero.
      reset               <= 1'b1;
      req_if.valid        <= 1'b0;
      req_if.action       <= ACT_QUERY;
      req_if.card_in      <= '0;
      req_if.position     <= '0;
      req_if.random_value <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_fisher_yates_pass();
      test_drain_past_empty();
      test_fill_past_full();
      test_fisher_yates_pass();
      test_response_backpressure();
      test_random_mix(80);

      // Run the last stretch at full rate: no gaps, no stalls.
      send_gaps_on   = 1'b0;
      sink_stalls_on = 1'b0;
      test_random_mix(50);
      req_if.valid <= 1'b0;

      // Drain the outstanding responses, then let the block settle.
      while (expect_wr != expect_rd) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Ran %0d actions: reset deck, shuffle passes, drain past empty, fill past full, ",
               actions_sent, "ring wrap and a long receiver hold-off");
      $display("Responses by status: ok %0d, draw empty %0d, add full %0d, out of range %0d",
               status_seen[STATUS_OK], status_seen[STATUS_DRAW_EMPTY],
               status_seen[STATUS_ADD_FULL], status_seen[STATUS_POS_RANGE]);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
